/* hdl/r2g_pkg.sv */
// ----------------------------------------------------------------------------
// r2g_pkg: shared types and constants of the 2D ray geometry unit
// Widths, operation and status codes, pipeline payload structs and the
// saturation and magnitude helpers used by the top module.
// ----------------------------------------------------------------------------
package r2g_pkg;

  // Coordinate format and derived widths.
  localparam int FRAC_BITS  = 16;
  localparam int CW         = 32;                   // coordinate width
  localparam int OW         = CW + 1;               // operand width after subtract or negate
  localparam int PW         = 2 * OW;               // product width
  localparam int RAD_W      = 2 * CW;               // square-root radicand width
  localparam int ROOT_W     = CW;                   // length width
  localparam int SQ_REM_W   = ROOT_W + 2;           // square-root remainder width
  localparam int TOL_W      = CW + 1;               // tolerance register width
  localparam int DIV_NW     = RAD_W + 2 + FRAC_BITS; // divider dividend and quotient width
  localparam int DIV_DW     = RAD_W + 1;            // divider divisor width
  localparam int LANES      = 4;                    // parallel divisions per item
  localparam int TERM_W     = DIV_NW + 1;           // signed quotient width
  localparam int SUM_W      = TERM_W + 2;           // width of a three-term sum

  // Port widths.
  localparam int IN_DATA_W  = 10 * CW;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 3 * CW;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    FN_AT_PARAM  = 2'd0,
    FN_AT_DIST   = 2'd1,
    FN_INTERSECT = 2'd2,
    FN_NEAREST   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_t;

  // Geometry terms produced by the front end.
  typedef struct packed {
    func_t                 func;
    logic                  exist_only;
    logic                  zero_dir;
    logic signed [CW-1:0]  ox;
    logic signed [CW-1:0]  oy;
    logic signed [PW-1:0]  det;
    logic signed [PW-1:0]  num;
    logic signed [PW-1:0]  n0;
    logic signed [PW-1:0]  n1;
    logic signed [PW-1:0]  n2;
    logic signed [PW-1:0]  n3;
  } r2g_geo_t;

  // Payload of one square-root cell.
  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [ROOT_W-1:0]   root;
    logic [SQ_REM_W-1:0] rem;
    r2g_geo_t            geo;
  } r2g_sq_t;

  // Side information that rides along the divider row.
  typedef struct packed {
    func_t                 func;
    status_t               status;
    logic                  zero_res;
    logic                  zero_dir;
    logic signed [CW-1:0]  ox;
    logic signed [CW-1:0]  oy;
    logic [LANES-1:0]      neg;
  } r2g_tag_t;

  // Payload of one divider cell: lanes 0 and 1 use d0, lanes 2 and 3 use d1.
  typedef struct packed {
    logic [DIV_DW-1:0]                  d0;
    logic [DIV_DW-1:0]                  d1;
    logic [LANES-1:0][DIV_DW-1:0]       rem;
    logic [LANES-1:0][DIV_NW-1:0]       num;
    r2g_tag_t                           tag;
  } r2g_div_t;

  // Magnitude of a signed product-width value.
  function automatic logic [PW-1:0] mag_p(input logic signed [PW-1:0] v);
    logic [PW-1:0] r;
    r = v[PW-1] ? PW'(-v) : PW'(v);
    return r;
  endfunction

  // Clamp a wide signed sum to the coordinate range.
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-CW:0]    top;
    logic signed [CW-1:0] r;
    top = v[SUM_W-1:CW-1];
    if (top == '0 || top == '1) begin
      r = v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hdl/r2g_front.sv */
// ----------------------------------------------------------------------------
// r2g_front: input register, multipliers and sums
// Registers the request, forms the six products of the selected operation
// and combines them into determinant, numerator and squared length.
// ----------------------------------------------------------------------------
module r2g_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          adv,
  input  logic                          in_valid,
  input  r2g_pkg::func_t                in_func,
  input  logic                          in_exist_only,
  input  logic signed [r2g_pkg::CW-1:0] in_origin_x,
  input  logic signed [r2g_pkg::CW-1:0] in_origin_y,
  input  logic signed [r2g_pkg::CW-1:0] in_dir_x,
  input  logic signed [r2g_pkg::CW-1:0] in_dir_y,
  input  logic signed [r2g_pkg::CW-1:0] in_other_x,
  input  logic signed [r2g_pkg::CW-1:0] in_other_y,
  input  logic signed [r2g_pkg::CW-1:0] in_other_dir_x,
  input  logic signed [r2g_pkg::CW-1:0] in_other_dir_y,
  input  logic signed [r2g_pkg::CW-1:0] in_amount,
  input  logic signed [r2g_pkg::CW-1:0] in_offset,
  output logic                          out_valid,
  output r2g_pkg::r2g_sq_t              out_data,
  output logic                          f0_busy
);
  import r2g_pkg::*;

  // Stage 0: request register.
  logic                 f0_valid_r;
  func_t                f0_func_r;
  logic                 f0_exist_r, f0_zero_r;
  logic signed [CW-1:0] f0_ox_r, f0_oy_r, f0_dx_r, f0_dy_r, f0_amt_r, f0_off_r;
  logic signed [OW-1:0] f0_ex_r, f0_ey_r, f0_dpx_r, f0_dpy_r;
  logic signed [OW-1:0] ex_nxt, ey_nxt;

  // Stage 1: products.
  logic                 f1_valid_r;
  func_t                f1_func_r;
  logic                 f1_exist_r, f1_zero_r;
  logic signed [CW-1:0] f1_ox_r, f1_oy_r;
  logic signed [PW-1:0] f1_a_r, f1_b_r, f1_c_r, f1_d_r, f1_e_r, f1_f_r;
  logic signed [OW-1:0] ma_b, mb_b, mc_a, mc_b, md_a, md_b;
  logic                 f0_pt;

  // Stage 2: sums.
  logic                 f2_valid_r;
  r2g_sq_t              f2_data_r;
  r2g_geo_t             geo_nxt;
  logic                 f1_pt;

  // The nearest query is an intersection with the perpendicular through the point.
  always_comb begin
    if (in_func == FN_NEAREST) begin
      ex_nxt = -OW'(in_dir_y);
      ey_nxt = OW'(in_dir_x);
    end else begin
      ex_nxt = OW'(in_other_dir_x);
      ey_nxt = OW'(in_other_dir_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_valid_r <= 1'b0;
    end else if (load) begin
      f0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f0_func_r  <= in_func;
      f0_exist_r <= in_exist_only;
      f0_zero_r  <= (in_dir_x == '0) && (in_dir_y == '0);
      f0_ox_r    <= in_origin_x;
      f0_oy_r    <= in_origin_y;
      f0_dx_r    <= in_dir_x;
      f0_dy_r    <= in_dir_y;
      f0_amt_r   <= in_amount;
      f0_off_r   <= in_offset;
      f0_ex_r    <= ex_nxt;
      f0_ey_r    <= ey_nxt;
      f0_dpx_r   <= OW'(in_origin_x) - OW'(in_other_x);
      f0_dpy_r   <= OW'(in_origin_y) - OW'(in_other_y);
    end
  end

  // The request register holds an item that has not moved on yet.
  assign f0_busy = f0_valid_r;

  // Operand selection: point modes need length and scaled direction terms.
  always_comb begin
    f0_pt = (f0_func_r == FN_AT_PARAM) || (f0_func_r == FN_AT_DIST);
    ma_b  = f0_pt ? OW'(f0_dx_r) : f0_ey_r;
    mb_b  = f0_pt ? OW'(f0_dy_r) : f0_ex_r;
    mc_a  = f0_pt ? OW'(f0_dx_r) : f0_dpy_r;
    mc_b  = f0_pt ? OW'(f0_amt_r) : f0_ex_r;
    md_a  = f0_pt ? OW'(f0_dy_r) : f0_dpx_r;
    md_b  = f0_pt ? OW'(f0_amt_r) : f0_ey_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= f0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_func_r  <= f0_func_r;
      f1_exist_r <= f0_exist_r;
      f1_zero_r  <= f0_zero_r;
      f1_ox_r    <= f0_ox_r;
      f1_oy_r    <= f0_oy_r;
      f1_a_r     <= OW'(f0_dx_r) * ma_b;
      f1_b_r     <= OW'(f0_dy_r) * mb_b;
      f1_c_r     <= mc_a * mc_b;
      f1_d_r     <= md_a * md_b;
      f1_e_r     <= OW'(f0_dy_r) * OW'(f0_off_r);
      f1_f_r     <= OW'(f0_dx_r) * OW'(f0_off_r);
    end
  end

  // Determinant, numerator and squared length.
  always_comb begin
    f1_pt              = (f1_func_r == FN_AT_PARAM) || (f1_func_r == FN_AT_DIST);
    geo_nxt.func       = f1_func_r;
    geo_nxt.exist_only = f1_exist_r;
    geo_nxt.zero_dir   = f1_zero_r;
    geo_nxt.ox         = f1_ox_r;
    geo_nxt.oy         = f1_oy_r;
    geo_nxt.det        = f1_a_r - f1_b_r;
    geo_nxt.num        = f1_c_r - f1_d_r;
    geo_nxt.n0         = f1_c_r;
    geo_nxt.n1         = f1_d_r;
    geo_nxt.n2         = -f1_e_r;
    geo_nxt.n3         = f1_f_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (adv) begin
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_data_r.rad  <= f1_pt ? RAD_W'(f1_a_r + f1_b_r) : '0;
      f2_data_r.root <= '0;
      f2_data_r.rem  <= '0;
      f2_data_r.geo  <= geo_nxt;
    end
  end

  assign out_valid = f2_valid_r;
  assign out_data  = f2_data_r;

endmodule

/* hdl/r2g_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// r2g_sqrt_cell: one step of the integer square-root row
// Takes two radicand bits, settles one root bit and passes the result on.
// ----------------------------------------------------------------------------
module r2g_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  r2g_pkg::r2g_sq_t  in_data,
  output logic              out_valid,
  output r2g_pkg::r2g_sq_t  out_data
);
  import r2g_pkg::*;

  logic                  valid_r;
  r2g_sq_t               data_r, data_nxt;
  logic [SQ_REM_W+1:0]   rem_s, trial;

  // Restoring step: try root*4+1 against the shifted remainder.
  always_comb begin
    data_nxt     = in_data;
    rem_s        = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
    trial        = (SQ_REM_W+2)'({in_data.root, 2'b01});
    data_nxt.rad = in_data.rad << 2;
    if (rem_s >= trial) begin
      data_nxt.rem  = SQ_REM_W'(rem_s - trial);
      data_nxt.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_nxt.rem  = SQ_REM_W'(rem_s);
      data_nxt.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hdl/r2g_div_cell.sv */
// ----------------------------------------------------------------------------
// r2g_div_cell: one step of the four-lane divider row
// Each lane shifts in one dividend bit, subtracts the divisor when it fits
// and shifts the quotient bit into the vacated dividend position.
// ----------------------------------------------------------------------------
module r2g_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  r2g_pkg::r2g_div_t  in_data,
  output logic               out_valid,
  output r2g_pkg::r2g_div_t  out_data
);
  import r2g_pkg::*;

  logic                valid_r;
  r2g_div_t            data_r, data_nxt;
  logic [DIV_DW:0]     rem_s [LANES];
  logic [DIV_DW:0]     dsr   [LANES];
  logic [LANES-1:0]    fits;

  // Lanes are independent; lanes 0 and 1 share d0, lanes 2 and 3 share d1.
  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < LANES; i++) begin
      dsr[i]   = (i < 2) ? {1'b0, in_data.d0} : {1'b0, in_data.d1};
      rem_s[i] = {in_data.rem[i], in_data.num[i][DIV_NW-1]};
      fits[i]  = rem_s[i] >= dsr[i];
      data_nxt.rem[i] = fits[i] ? DIV_DW'(rem_s[i] - dsr[i]) : DIV_DW'(rem_s[i]);
      data_nxt.num[i] = {in_data.num[i][DIV_NW-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hdl/ray2d_geometry_unit.sv */
// ----------------------------------------------------------------------------
// ray2d_geometry_unit: pipelined 2D ray geometry in Q16.16
// Point at parameter or distance with sideways offset, ray crossing
// parameter and perpendicular foot parameter, with saturated results.
//
//   Group  Direction  Carries
//   in_*   slave      one query: operation, rays, amount, offset
//   out_*  master     one result: point, parameter, status
//   cfg_*  slave      parallel tolerance register write
//
// One request enters per cycle unless the out side stalls; the path runs
// through the 32-cell square-root row and the 82-cell divider.
// Reset empties the pipeline and sets the tolerance to 1.
// A stalled out side freezes all stages; in_tready stays high while the
// input register is empty. cfg_ready is always high.
// ----------------------------------------------------------------------------
module ray2d_geometry_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // origin_x, origin_y, dir_x, dir_y, other_x, other_y, other_dir_x,
  // other_dir_y, amount, offset (32 bits each)
  input  logic [r2g_pkg::IN_DATA_W-1:0]      in_tdata,
  // func [1:0], exist_only [2]
  input  logic [r2g_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // point_x, point_y, param (32 bits each)
  output logic [r2g_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status [1:0]
  output logic [r2g_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [r2g_pkg::TOL_W-1:0]          cfg_data
);
  import r2g_pkg::*;

  logic               adv;
  logic               front_busy;
  logic [TOL_W-1:0]   tol_r;

  logic               sq_v [ROOT_W+1];
  r2g_sq_t            sq_d [ROOT_W+1];
  logic               dv_v [DIV_NW+1];
  r2g_div_t           dv_d [DIV_NW+1];

  // Prep stage signals.
  r2g_sq_t            pq;
  logic               p_pt, p_par;
  logic [ROOT_W-1:0]  p_len;
  logic [DIV_DW-1:0]  p_da;
  logic [RAD_W-1:0]   p_adet;
  r2g_div_t           p_nxt;

  // Back end.
  logic                     b_valid_r;
  r2g_tag_t                 b_tag_r;
  logic signed [TERM_W-1:0] b_t_r [LANES];
  logic signed [TERM_W-1:0] b_t_nxt [LANES];
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [CW-1:0]     px_nxt, py_nxt, pr_nxt;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0]    out_user_r;

  // Every stage moves when the output register is free or being emptied.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv || !front_busy;

  // Tolerance register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  r2g_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_tready),
    .adv            (adv),
    .in_valid       (in_tvalid),
    .in_func        (func_t'(in_tuser[1:0])),
    .in_exist_only  (in_tuser[2]),
    .in_origin_x    (in_tdata[0*CW +: CW]),
    .in_origin_y    (in_tdata[1*CW +: CW]),
    .in_dir_x       (in_tdata[2*CW +: CW]),
    .in_dir_y       (in_tdata[3*CW +: CW]),
    .in_other_x     (in_tdata[4*CW +: CW]),
    .in_other_y     (in_tdata[5*CW +: CW]),
    .in_other_dir_x (in_tdata[6*CW +: CW]),
    .in_other_dir_y (in_tdata[7*CW +: CW]),
    .in_amount      (in_tdata[8*CW +: CW]),
    .in_offset      (in_tdata[9*CW +: CW]),
    .out_valid      (sq_v[0]),
    .out_data       (sq_d[0]),
    .f0_busy        (front_busy)
  );

  // Square-root row: one root bit per cell.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    r2g_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (sq_v[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // Prep stage: status, rounding offsets and divider operands.
  always_comb begin
    pq     = sq_d[ROOT_W];
    p_len  = pq.root;
    p_pt   = (pq.geo.func == FN_AT_PARAM) || (pq.geo.func == FN_AT_DIST);
    p_da   = (pq.geo.func == FN_AT_PARAM) ? DIV_DW'(1) << FRAC_BITS : DIV_DW'(p_len);
    p_adet = RAD_W'(mag_p(pq.geo.det));
    p_par  = (p_adet == '0) || (p_adet < RAD_W'(tol_r));

    p_nxt.tag.func     = pq.geo.func;
    p_nxt.tag.zero_dir = pq.geo.zero_dir;
    p_nxt.tag.ox       = pq.geo.ox;
    p_nxt.tag.oy       = pq.geo.oy;
    if (pq.geo.zero_dir) begin
      p_nxt.tag.status = ST_ZERO_DIR;
    end else if (!p_pt && p_par) begin
      p_nxt.tag.status = ST_PARALLEL;
    end else begin
      p_nxt.tag.status = ST_OK;
    end
    p_nxt.tag.zero_res = (p_nxt.tag.status != ST_OK) ||
                         ((pq.geo.func == FN_INTERSECT) && pq.geo.exist_only);

    // Rounded division: floor((2|n| + d) / 2d), sign applied afterwards.
    if (p_pt) begin
      p_nxt.num[0] = (DIV_NW'(mag_p(pq.geo.n0)) << 1) + DIV_NW'(p_da);
      p_nxt.d0     = p_da << 1;
      p_nxt.tag.neg[0] = pq.geo.n0[PW-1];
    end else begin
      p_nxt.num[0] = (DIV_NW'(mag_p(pq.geo.num)) << (FRAC_BITS + 1)) + DIV_NW'(p_adet);
      p_nxt.d0     = DIV_DW'(p_adet) << 1;
      p_nxt.tag.neg[0] = pq.geo.num[PW-1] ^ pq.geo.det[PW-1];
    end
    p_nxt.num[1] = (DIV_NW'(mag_p(pq.geo.n1)) << 1) + DIV_NW'(p_da);
    p_nxt.num[2] = (DIV_NW'(mag_p(pq.geo.n2)) << 1) + DIV_NW'(p_len);
    p_nxt.num[3] = (DIV_NW'(mag_p(pq.geo.n3)) << 1) + DIV_NW'(p_len);
    p_nxt.tag.neg[1] = pq.geo.n1[PW-1];
    p_nxt.tag.neg[2] = pq.geo.n2[PW-1];
    p_nxt.tag.neg[3] = pq.geo.n3[PW-1];
    p_nxt.d1  = DIV_DW'(p_len) << 1;
    p_nxt.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_d[0] <= p_nxt;
    end
  end

  // Divider row: one quotient bit per cell in each lane.
  for (genvar k = 0; k < DIV_NW; k++) begin : g_div
    r2g_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv_v[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  // Apply the signs to the quotients.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      b_t_nxt[i] = $signed({1'b0, dv_d[DIV_NW].num[i]});
      if (dv_d[DIV_NW].tag.neg[i]) begin
        b_t_nxt[i] = -b_t_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= dv_v[DIV_NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag_r <= dv_d[DIV_NW].tag;
      for (int i = 0; i < LANES; i++) begin
        b_t_r[i] <= b_t_nxt[i];
      end
    end
  end

  // Final sums, saturation and unused-field clearing.
  always_comb begin
    sum_x = SUM_W'(b_tag_r.ox) + SUM_W'(b_t_r[0]) + SUM_W'(b_t_r[2]);
    sum_y = SUM_W'(b_tag_r.oy) + SUM_W'(b_t_r[1]) + SUM_W'(b_t_r[3]);
    px_nxt = '0;
    py_nxt = '0;
    pr_nxt = '0;
    if ((b_tag_r.func == FN_AT_PARAM) || (b_tag_r.func == FN_AT_DIST)) begin
      if (b_tag_r.zero_dir) begin
        px_nxt = b_tag_r.ox;
        py_nxt = b_tag_r.oy;
      end else begin
        px_nxt = sat_coord(sum_x);
        py_nxt = sat_coord(sum_y);
      end
    end else if (!b_tag_r.zero_res) begin
      pr_nxt = sat_coord(SUM_W'(b_t_r[0]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {pr_nxt, py_nxt, px_nxt};
      out_user_r <= b_tag_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A pipeline that comes out of reset shows no result.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Parallel or degenerate results never carry a parameter.
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_PARALLEL) |-> out_tdata[3*CW-1:2*CW] == '0)
    else $error("parallel result with nonzero parameter");

  a_zdir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ZERO_DIR) |-> out_tdata[3*CW-1:2*CW] == '0)
    else $error("zero-direction result with nonzero parameter");

  // A stall freezes the inner stages.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(b_valid_r) && $stable(dv_v[0]))
    else $error("inner stage moved during a stall");

endmodule
